@@ sv/sqlts_pkg.sv @@
// ----------------------------------------------------------------------------
// sqlts_pkg: shared types, codes and character helpers
// Item layouts, token kind and error codes, keyword table and the
// character-class functions used by the scanner core.
// ----------------------------------------------------------------------------
package sqlts_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } scan_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic [7:0]  error_byte;
    logic        last_of_item;
  } token_t;

  // Token kinds
  localparam logic [4:0] KIND_STAR   = 5'd0;
  localparam logic [4:0] KIND_COMMA  = 5'd1;
  localparam logic [4:0] KIND_DOT    = 5'd2;
  localparam logic [4:0] KIND_LPAREN = 5'd3;
  localparam logic [4:0] KIND_RPAREN = 5'd4;
  localparam logic [4:0] KIND_SEMI   = 5'd5;
  localparam logic [4:0] KIND_EQ     = 5'd6;
  localparam logic [4:0] KIND_NE     = 5'd7;
  localparam logic [4:0] KIND_GT     = 5'd8;
  localparam logic [4:0] KIND_GE     = 5'd9;
  localparam logic [4:0] KIND_LT     = 5'd10;
  localparam logic [4:0] KIND_LE     = 5'd11;
  localparam logic [4:0] KIND_STRING = 5'd12;
  localparam logic [4:0] KIND_NUMBER = 5'd13;
  localparam logic [4:0] KIND_IDENT  = 5'd14;
  localparam logic [4:0] KIND_KW0    = 5'd15;
  localparam logic [4:0] KIND_EOF    = 5'd21;
  // Error results carry kind zero
  localparam logic [4:0] KIND_ERROR  = 5'd0;

  // Error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG     = 2'd3;

  // Characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Keywords, folded to upper case, first character in the low byte
  localparam int unsigned NUM_KEYWORDS = 6;
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h0000_5452_4553_4E49,   // INSERT
    64'h0000_0000_4F54_4E49,   // INTO
    64'h0000_5345_554C_4156,   // VALUES
    64'h0000_5443_454C_4553,   // SELECT
    64'h0000_0000_4D4F_5246,   // FROM
    64'h0000_0045_5245_4857    // WHERE
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

  // len is the identifier length, clipped to 4'hF when longer than eight
  function automatic logic [4:0] word_kind(input logic [63:0] word, input logic [3:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if ((len == KW_LEN[k]) && (word == KW_TEXT[k])) begin
        kind = KIND_KW0 + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

@@ sv/sqlts_if.sv @@
// ----------------------------------------------------------------------------
// sqlts channels: valid/ready interfaces for text bytes and tokens
// One interface per channel; payload fields travel beside valid and ready.
// ----------------------------------------------------------------------------
interface sqlts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface sqlts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [1:0]  error_code;
  logic [7:0]  error_byte;
  logic        last_of_item;

  modport source (output valid, token_kind, start_offset, token_length, error_code,
                  error_byte, last_of_item, input ready);
  modport sink   (input valid, token_kind, start_offset, token_length, error_code,
                  error_byte, last_of_item, output ready);
endinterface

@@ sv/sqlts_core.sv @@
// ----------------------------------------------------------------------------
// sqlts_core: scanner state and per-byte token logic
// Holds the scan mode and token bookkeeping; for one byte it produces up
// to two tokens (the one it closes, then the one it starts or ends).
// ----------------------------------------------------------------------------
module sqlts_core #(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  sqlts_pkg::scan_item_t item,
  output logic [1:0]          res_n,
  output sqlts_pkg::token_t   res0,
  output sqlts_pkg::token_t   res1
);
  import sqlts_pkg::*;

  localparam int WORD_BITS  = 8 * KEYWORD_CHARS;
  localparam int COUNT_BITS = $clog2(KEYWORD_CHARS + 1);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_CMP    = 3'd1;
  localparam logic [2:0] MODE_SIGN   = 3'd2;
  localparam logic [2:0] MODE_NUMBER = 3'd3;
  localparam logic [2:0] MODE_IDENT  = 3'd4;
  localparam logic [2:0] MODE_STRING = 3'd5;
  localparam logic [2:0] MODE_HALT   = 3'd6;

  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;
  localparam logic [OFFSET_BITS-1:0] LEN_ONE   = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] LEN_TWO   = OFFSET_BITS'(2);

  logic [2:0]             scan_mode,     scan_mode_next;
  logic [7:0]             pending_char,  pending_char_next;
  logic [OFFSET_BITS-1:0] token_begin,   token_begin_next;
  logic [OFFSET_BITS-1:0] text_position, text_position_next;
  logic [WORD_BITS-1:0]   folded_word,   folded_word_next;
  logic [COUNT_BITS-1:0]  word_count,    word_count_next;

  logic [7:0]             c;
  logic [7:0]             fold_c;
  logic                   at_end;
  logic [OFFSET_BITS-1:0] span;
  logic [3:0]             len_code;
  logic [4:0]             ident_kind;
  logic [4:0]             short_kind;
  logic [4:0]             long_kind;
  logic [WORD_BITS-1:0]   fold_app;
  logic [COUNT_BITS-1:0]  count_app;

  logic                   sc_v, sc_take, sc_ident;
  logic [2:0]             sc_mode;
  logic [4:0]             sc_kind;
  token_t                 sc_tok;

  logic                   use_scan;
  logic                   lead_v, tail_v;
  token_t                 lead_tok, tail_tok;

  function automatic token_t make_tok(input logic [4:0] kind,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [OFFSET_BITS-1:0] len,
                                      input logic [1:0] err,
                                      input logic [7:0] eb);
    token_t t;
    t.token_kind   = kind;
    t.start_offset = 16'(start);
    t.token_length = 16'(len);
    t.error_code   = err;
    t.error_byte   = eb;
    t.last_of_item = 1'b0;
    return t;
  endfunction

  // Character classes and the token a byte starts from idle
  always_comb begin
    c          = item.text_byte;
    at_end     = item.end_of_text || (c == 8'h00);
    fold_c     = to_upper(c);
    span       = text_position - token_begin;
    len_code   = (span <= OFFSET_BITS'(8)) ? 4'(span) : 4'hF;
    ident_kind = word_kind(64'(folded_word), len_code);
    short_kind = (pending_char == CH_LT) ? KIND_LT : KIND_GT;
    long_kind  = (pending_char == CH_BANG) ? KIND_NE :
                 ((pending_char == CH_LT) ? KIND_LE : KIND_GE);

    fold_app = folded_word;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (word_count == COUNT_BITS'(i)) begin
        fold_app[8*i +: 8] = fold_c;
      end
    end
    count_app = (word_count < COUNT_BITS'(KEYWORD_CHARS)) ? word_count + 1'b1 : word_count;

    sc_v     = 1'b0;
    sc_take  = 1'b0;
    sc_ident = 1'b0;
    sc_mode  = MODE_IDLE;
    sc_kind  = KIND_STAR;
    sc_tok   = '0;
    if (!is_space(c)) begin
      case (c)
        CH_STAR:   sc_kind = KIND_STAR;
        CH_COMMA:  sc_kind = KIND_COMMA;
        CH_DOT:    sc_kind = KIND_DOT;
        CH_LPAREN: sc_kind = KIND_LPAREN;
        CH_RPAREN: sc_kind = KIND_RPAREN;
        CH_SEMI:   sc_kind = KIND_SEMI;
        CH_EQ:     sc_kind = KIND_EQ;
        default: begin
          sc_take = 1'b1;
          if ((c == CH_BANG) || (c == CH_LT) || (c == CH_GT)) begin
            sc_mode = MODE_CMP;
          end else if (c == CH_QUOTE) begin
            sc_mode = MODE_STRING;
          end else if (is_digit(c)) begin
            sc_mode = MODE_NUMBER;
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            sc_mode = MODE_SIGN;
          end else if (is_alpha(c) || (c == CH_UNDER)) begin
            sc_mode  = MODE_IDENT;
            sc_ident = 1'b1;
          end else begin
            sc_v    = 1'b1;
            sc_mode = MODE_HALT;
            sc_tok  = make_tok(KIND_ERROR, text_position, '0, ERR_UNEXPECTED, c);
          end
        end
      endcase
      // One-character punctuation closes at once
      if (!sc_take) begin
        sc_v   = 1'b1;
        sc_tok = make_tok(sc_kind, text_position, LEN_ONE, ERR_NONE, 8'h00);
      end
    end
  end

  // Mode update and result selection
  always_comb begin
    scan_mode_next     = scan_mode;
    pending_char_next  = pending_char;
    token_begin_next   = token_begin;
    text_position_next = text_position;
    folded_word_next   = folded_word;
    word_count_next    = word_count;
    use_scan = 1'b0;
    lead_v   = 1'b0;
    tail_v   = 1'b0;
    lead_tok = '0;
    tail_tok = '0;

    if (at_end) begin
      unique case (scan_mode)
        MODE_HALT: ;
        MODE_CMP: begin
          if (pending_char == CH_BANG) begin
            lead_v   = 1'b1;
            lead_tok = make_tok(KIND_ERROR, token_begin, '0, ERR_UNEXPECTED, pending_char);
          end else begin
            lead_v   = 1'b1;
            lead_tok = make_tok(short_kind, token_begin, LEN_ONE, ERR_NONE, 8'h00);
            tail_v   = 1'b1;
            tail_tok = make_tok(KIND_EOF, text_position, '0, ERR_NONE, 8'h00);
          end
        end
        MODE_SIGN: begin
          lead_v   = 1'b1;
          lead_tok = make_tok(KIND_ERROR, token_begin, '0, ERR_UNEXPECTED, pending_char);
        end
        MODE_STRING: begin
          lead_v   = 1'b1;
          lead_tok = make_tok(KIND_ERROR, token_begin, '0, ERR_UNTERMINATED, 8'h00);
        end
        MODE_NUMBER: begin
          lead_v   = 1'b1;
          lead_tok = make_tok(KIND_NUMBER, token_begin, span, ERR_NONE, 8'h00);
          tail_v   = 1'b1;
          tail_tok = make_tok(KIND_EOF, text_position, '0, ERR_NONE, 8'h00);
        end
        MODE_IDENT: begin
          lead_v   = 1'b1;
          lead_tok = make_tok(ident_kind, token_begin, span, ERR_NONE, 8'h00);
          tail_v   = 1'b1;
          tail_tok = make_tok(KIND_EOF, text_position, '0, ERR_NONE, 8'h00);
        end
        default: begin
          tail_v   = 1'b1;
          tail_tok = make_tok(KIND_EOF, text_position, '0, ERR_NONE, 8'h00);
        end
      endcase
      scan_mode_next     = MODE_IDLE;
      pending_char_next  = '0;
      token_begin_next   = '0;
      text_position_next = '0;
      folded_word_next   = '0;
      word_count_next    = '0;
    end else if (scan_mode != MODE_HALT) begin
      if (text_position == POS_LIMIT) begin
        lead_v         = 1'b1;
        lead_tok       = make_tok(KIND_ERROR, text_position, '0, ERR_TOO_LONG, 8'h00);
        scan_mode_next = MODE_HALT;
      end else begin
        text_position_next = text_position + 1'b1;
        unique case (scan_mode)
          MODE_CMP: begin
            if (c == CH_EQ) begin
              lead_v         = 1'b1;
              lead_tok       = make_tok(long_kind, token_begin, LEN_TWO, ERR_NONE, 8'h00);
              scan_mode_next = MODE_IDLE;
            end else if (pending_char == CH_BANG) begin
              lead_v         = 1'b1;
              lead_tok       = make_tok(KIND_ERROR, token_begin, '0, ERR_UNEXPECTED, pending_char);
              scan_mode_next = MODE_HALT;
            end else begin
              lead_v   = 1'b1;
              lead_tok = make_tok(short_kind, token_begin, LEN_ONE, ERR_NONE, 8'h00);
              use_scan = 1'b1;
            end
          end
          MODE_SIGN: begin
            if (is_digit(c)) begin
              scan_mode_next = MODE_NUMBER;
            end else begin
              lead_v         = 1'b1;
              lead_tok       = make_tok(KIND_ERROR, token_begin, '0, ERR_UNEXPECTED, pending_char);
              scan_mode_next = MODE_HALT;
            end
          end
          MODE_NUMBER: begin
            if (!is_digit(c)) begin
              lead_v   = 1'b1;
              lead_tok = make_tok(KIND_NUMBER, token_begin, span, ERR_NONE, 8'h00);
              use_scan = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_word(c)) begin
              folded_word_next = fold_app;
              word_count_next  = count_app;
            end else begin
              lead_v   = 1'b1;
              lead_tok = make_tok(ident_kind, token_begin, span, ERR_NONE, 8'h00);
              use_scan = 1'b1;
            end
          end
          MODE_STRING: begin
            if (c == CH_QUOTE) begin
              lead_v         = 1'b1;
              lead_tok       = make_tok(KIND_STRING, token_begin, span + 1'b1, ERR_NONE, 8'h00);
              scan_mode_next = MODE_IDLE;
            end
          end
          default: use_scan = 1'b1;
        endcase

        if (use_scan) begin
          scan_mode_next = sc_mode;
          tail_v         = sc_v;
          tail_tok       = sc_tok;
          if (sc_take) begin
            token_begin_next  = text_position;
            pending_char_next = c;
          end
          if (sc_ident) begin
            folded_word_next = WORD_BITS'(fold_c);
            word_count_next  = COUNT_BITS'(1);
          end
        end
      end
    end

    // The tail token, when present, always closes the item
    tail_tok.last_of_item = 1'b1;
    lead_tok.last_of_item = !tail_v;
    res_n = {1'b0, lead_v} + {1'b0, tail_v};
    res0  = lead_v ? lead_tok : tail_tok;
    res1  = tail_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      pending_char  <= '0;
      token_begin   <= '0;
      text_position <= '0;
      folded_word   <= '0;
      word_count    <= '0;
    end else if (fire) begin
      scan_mode     <= scan_mode_next;
      pending_char  <= pending_char_next;
      token_begin   <= token_begin_next;
      text_position <= text_position_next;
      folded_word   <= folded_word_next;
      word_count    <= word_count_next;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && at_end |=> (text_position == '0) && (scan_mode == MODE_IDLE))
    else $error("text did not restart after end of text");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    fire && (scan_mode == MODE_HALT) && !at_end |-> (res_n == 2'd0))
    else $error("halted scanner produced a token");

  a_idle_end_eof: assert property (@(posedge clk) disable iff (rst)
    fire && at_end && (scan_mode == MODE_IDLE) |->
      (res_n == 2'd1) && (res0.token_kind == KIND_EOF) && res0.last_of_item)
    else $error("idle end of text must give a single eof token");

endmodule

@@ sv/sqlts_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sqlts_out_fifo: four-entry token queue
// Takes zero, one or two tokens per cycle and hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module sqlts_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  sqlts_pkg::token_t res0,
  input  sqlts_pkg::token_t res1,
  output logic              room,
  output logic              head_valid,
  output sqlts_pkg::token_t head,
  input  logic              pop
);
  import sqlts_pkg::*;

  localparam int DEPTH = 4;

  token_t     mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign room       = (count <= 3'd2);
  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> (count <= 3'd2))
    else $error("token queue pushed without room for two");

endmodule

@@ sv/sql_token_scanner.sv @@
// ----------------------------------------------------------------------------
// sql_token_scanner: streaming SQL lexer, one text byte per item
// Feed SQL text on text_in one byte per item; an item with end_of_text set
// (or a zero text_byte) closes the text. Tokens leave on token_out as kind,
// start offset and length, with error_code/error_byte for the single error
// result of a bad text; last_of_item marks the final token of an input byte.
// A byte accepted on text_in sits in the input register until the queue
// has room; it is then scanned and its first token is offered on token_out.
// Throughput: one byte per cycle while token_out is ready and each byte
// yields at most one token; a byte that yields two (close plus eof, or close
// plus a one-char token or error) leaves them in the four-entry token queue.
// The scanner advances only when the queue has room for two tokens.
// Stall: when token_out is held, tokens wait in the queue, then the input
// register fills and text_in.ready drops; nothing is lost or repeated.
// Reset: clears the scan state, the input register and the queue; the
// first byte after reset is offset 0 of a new text.
// ----------------------------------------------------------------------------
module sql_token_scanner #(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic        clk,
  input  logic        rst,
  sqlts_in_if.sink    text_in,
  sqlts_out_if.source token_out
);
  import sqlts_pkg::*;

  logic       s1_valid;
  scan_item_t s1_item;
  logic       accept;
  logic       fire;
  logic       room;
  logic [1:0] core_n;
  logic [1:0] push_n;
  token_t     res0;
  token_t     res1;
  logic       head_valid;
  token_t     head;
  logic       pop;

  // Scan the held byte once the queue can take both possible tokens
  assign fire          = s1_valid && room;
  assign text_in.ready = !s1_valid || fire;
  assign accept        = text_in.valid && text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Hold the byte payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.text_byte   <= text_in.text_byte;
      s1_item.end_of_text <= text_in.end_of_text;
    end
  end

  sqlts_core #(
    .OFFSET_BITS   (OFFSET_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (s1_item),
    .res_n (core_n),
    .res0  (res0),
    .res1  (res1)
  );

  // Drop the core's tokens unless the held byte is really scanned
  assign push_n = fire ? core_n : 2'd0;

  sqlts_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .res0       (res0),
    .res1       (res1),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  assign pop                    = head_valid && token_out.ready;
  assign token_out.valid        = head_valid;
  assign token_out.token_kind   = head.token_kind;
  assign token_out.start_offset = head.start_offset;
  assign token_out.token_length = head.token_length;
  assign token_out.error_code   = head.error_code;
  assign token_out.error_byte   = head.error_byte;
  assign token_out.last_of_item = head.last_of_item;

endmodule
